// ===== rtl/core/pn_pkg.sv =====
// ----------------------------------------------------------------------------
// pn_pkg
// Shared types, constants and helpers for the path normalizer.
// ----------------------------------------------------------------------------
package pn_pkg;

    localparam int PATH_BYTES   = 64;
    localparam int MAX_SEGMENTS = 64;

    localparam int CFG_W  = 7;
    localparam int CHAR_W = 8;
    localparam int ADDR_W = $clog2(PATH_BYTES);
    localparam int SEG_AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int SEG_W  = 2 * CFG_W;

    localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

    localparam logic [CFG_W-1:0] BUF_RESET = 7'd64;
    localparam logic [CFG_W-1:0] MIN_SIZE  = 7'd2;

    typedef logic [CFG_W-1:0] len_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [CHAR_W-1:0] data;
    } char_wr_t;

    typedef struct packed {
        logic              en;
        logic [SEG_AW-1:0] addr;
        logic [SEG_W-1:0]  data;
    } seg_wr_t;

    // Status from the parser to the emitter.
    typedef struct packed {
        logic             term;
        logic [CNT_W-1:0] stack_depth;
    } path_info_t;

    typedef enum logic [2:0] {
        EM_IDLE,
        EM_START,
        EM_SEG_EVAL,
        EM_BYTES,
        EM_SEG_END,
        EM_SEG_NEXT,
        EM_FINISH
    } em_state_t;

    // Buffer size saturated to the range the datapath supports.
    function automatic len_t eff_size(input len_t v);
        len_t r;
        r = v;
        if (v < MIN_SIZE) r = MIN_SIZE;
        if (v > CFG_W'(PATH_BYTES)) r = CFG_W'(PATH_BYTES);
        return r;
    endfunction

endpackage

// ===== rtl/core/pn_char_mem.sv =====
// ----------------------------------------------------------------------------
// pn_char_mem
// Byte store for the incoming path: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pn_char_mem
    import pn_pkg::*;
(
    input  logic              clk,
    input  char_wr_t          wr,
    input  logic [ADDR_W-1:0] raddr,
    output logic [CHAR_W-1:0] rdata
);

    logic [CHAR_W-1:0] mem [PATH_BYTES];
    logic [CHAR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/pn_seg_mem.sv =====
// ----------------------------------------------------------------------------
// pn_seg_mem
// Segment stack storage: each entry holds a start index and a length.
// ----------------------------------------------------------------------------
module pn_seg_mem
    import pn_pkg::*;
(
    input  logic              clk,
    input  seg_wr_t           wr,
    input  logic [SEG_AW-1:0] raddr,
    output logic [SEG_W-1:0]  rdata
);

    logic [SEG_W-1:0] mem [MAX_SEGMENTS];
    logic [SEG_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/pn_parser.sv =====
// ----------------------------------------------------------------------------
// pn_parser
// Stores incoming bytes and maintains the segment stack as components close.
// ----------------------------------------------------------------------------
module pn_parser
    import pn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [CHAR_W-1:0] path_char,
    input  len_t              size,
    input  logic              done,
    output char_wr_t          char_wr,
    output seg_wr_t           seg_wr,
    output path_info_t        info
);

    len_t             pos_reg, pos_next;
    len_t             cstart_reg, cstart_next;
    logic             dot0_reg, dot0_next;
    logic             dot1_reg, dot1_next;
    logic [CNT_W-1:0] count_reg, count_next;

    len_t limit;
    len_t close_end;
    len_t close_len;
    logic do_close;
    logic is_dot;
    logic is_slash;

    always_comb
    begin
        limit    = size - CFG_W'(1);
        is_dot   = (path_char == CHAR_DOT);
        is_slash = (path_char == CHAR_SLASH);

        pos_next    = pos_reg;
        cstart_next = cstart_reg;
        dot0_next   = dot0_reg;
        dot1_next   = dot1_reg;
        count_next  = count_reg;
        char_wr     = '{en: 1'b0, addr: pos_reg[ADDR_W-1:0], data: path_char};
        do_close    = 1'b0;
        close_end   = pos_reg;

        if (accept && path_char != CHAR_NUL)
        begin
            if (pos_reg == '0 && !is_slash)
            begin
                // Implicit leading slash: position 0 is never read back.
                cstart_next = CFG_W'(1);
                if (CFG_W'(1) < limit)
                begin
                    char_wr.en   = 1'b1;
                    char_wr.addr = ADDR_W'(1);
                    pos_next     = CFG_W'(2);
                    dot0_next    = is_dot;
                end
                else
                begin
                    pos_next = CFG_W'(1);
                end
            end
            else if (pos_reg < limit)
            begin
                char_wr.en = 1'b1;
                pos_next   = pos_reg + CFG_W'(1);
                if (is_slash)
                begin
                    do_close    = 1'b1;
                    cstart_next = pos_reg + CFG_W'(1);
                end
                else
                begin
                    if (pos_reg == cstart_reg) dot0_next = is_dot;
                    if (pos_reg == cstart_reg + CFG_W'(1)) dot1_next = is_dot;
                end
            end
        end
        else if (accept)
        begin
            // Terminator closes the last component and rewinds the input.
            do_close    = 1'b1;
            pos_next    = '0;
            cstart_next = '0;
        end

        close_len = close_end - cstart_reg;
        seg_wr    = '{en: 1'b0, addr: count_reg[SEG_AW-1:0],
                      data: {cstart_reg, close_len}};
        if (do_close && close_end > cstart_reg)
        begin
            if (close_len == CFG_W'(1) && dot0_reg)
            begin
                count_next = count_reg;
            end
            else if (close_len == CFG_W'(2) && dot0_reg && dot1_reg)
            begin
                if (count_reg != '0) count_next = count_reg - CNT_W'(1);
            end
            else if (count_reg < CNT_W'(MAX_SEGMENTS))
            begin
                seg_wr.en  = 1'b1;
                count_next = count_reg + CNT_W'(1);
            end
        end

        if (done) count_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            cstart_reg <= '0;
            dot0_reg   <= 1'b0;
            dot1_reg   <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            cstart_reg <= cstart_next;
            dot0_reg   <= dot0_next;
            dot1_reg   <= dot1_next;
            count_reg  <= count_next;
        end
    end

    assign info.term        = accept && (path_char == CHAR_NUL);
    assign info.stack_depth = count_reg;

endmodule

// ===== rtl/core/pn_emitter.sv =====
// ----------------------------------------------------------------------------
// pn_emitter
// Walks the segment stack and streams the rebuilt path from the byte store.
// ----------------------------------------------------------------------------
module pn_emitter
    import pn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  path_info_t        info,
    input  len_t              size,
    input  logic [SEG_W-1:0]  seg_rdata,
    input  logic [CHAR_W-1:0] char_rdata,
    output logic [SEG_AW-1:0] seg_raddr,
    output logic [ADDR_W-1:0] char_raddr,
    output logic              busy,
    output logic              done,
    output logic              out_valid,
    output logic [CHAR_W-1:0] out_char,
    output logic              out_last
);

    em_state_t state_reg, state_next;

    len_t              b_reg, b_next;
    len_t              pos_reg, pos_next;
    len_t              rem_reg, rem_next;
    logic [CNT_W-1:0]  s_reg, s_next;
    logic [ADDR_W-1:0] cidx_reg, cidx_next;
    logic              rd_vld_reg, rd_vld_next;
    logic              pend_vld_reg, pend_vld_next;
    logic [CHAR_W-1:0] pend_char_reg, pend_char_next;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic              out_last_reg, out_last_next;

    len_t             seg_begin;
    len_t             seg_len;
    len_t             len_eff;
    logic [CFG_W:0]   sum_w;
    logic             fits;
    logic             allow_ok;
    logic             slash_ok;
    logic [CNT_W-1:0] s_plus;
    logic             last_seg;
    logic             new_vld;
    logic [CHAR_W-1:0] new_char;

    always_comb
    begin
        seg_begin = seg_rdata[SEG_W-1:CFG_W];
        seg_len   = seg_rdata[CFG_W-1:0];
        sum_w     = {1'b0, pos_reg} + {1'b0, seg_len} + (CFG_W+1)'(1);
        fits      = sum_w < {1'b0, b_reg};
        allow_ok  = {1'b0, b_reg} > ({1'b0, pos_reg} + (CFG_W+1)'(2));
        len_eff   = fits ? seg_len : (b_reg - pos_reg - CFG_W'(2));
        slash_ok  = ({1'b0, pos_reg} + (CFG_W+1)'(1)) < {1'b0, b_reg};
        s_plus    = s_reg + CNT_W'(1);
        last_seg  = (s_plus == info.stack_depth);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            EM_IDLE:
            begin
                if (info.term) state_next = EM_START;
            end
            EM_START:
            begin
                state_next = (info.stack_depth == '0) ? EM_FINISH : EM_SEG_EVAL;
            end
            EM_SEG_EVAL:
            begin
                state_next = (!fits && !allow_ok) ? EM_FINISH : EM_BYTES;
            end
            EM_BYTES:
            begin
                if (rem_reg == CFG_W'(1)) state_next = EM_SEG_END;
            end
            EM_SEG_END:
            begin
                state_next = EM_SEG_NEXT;
            end
            EM_SEG_NEXT:
            begin
                state_next = (last_seg || !slash_ok) ? EM_FINISH : EM_SEG_EVAL;
            end
            EM_FINISH:
            begin
                state_next = EM_IDLE;
            end
            default:
            begin
                state_next = EM_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        busy       = (state_reg != EM_IDLE);
        done       = (state_reg == EM_FINISH);
        char_raddr = cidx_reg;
        new_vld    = rd_vld_reg;
        new_char   = char_rdata;
        case (state_reg)
            EM_START:
            begin
                seg_raddr = '0;
                new_vld   = 1'b1;
                new_char  = CHAR_SLASH;
            end
            EM_SEG_NEXT:
            begin
                seg_raddr = s_plus[SEG_AW-1:0];
                if (!last_seg && slash_ok)
                begin
                    new_vld  = 1'b1;
                    new_char = CHAR_SLASH;
                end
            end
            default:
            begin
                seg_raddr = s_reg[SEG_AW-1:0];
            end
        endcase
    end

    // Datapath.
    always_comb
    begin
        b_next         = b_reg;
        pos_next       = pos_reg;
        rem_next       = rem_reg;
        s_next         = s_reg;
        cidx_next      = cidx_reg;
        rd_vld_next    = (state_reg == EM_BYTES);
        pend_vld_next  = pend_vld_reg;
        pend_char_next = pend_char_reg;
        out_valid_next = 1'b0;
        out_char_next  = out_char_reg;
        out_last_next  = 1'b0;

        case (state_reg)
            EM_IDLE:
            begin
                b_next = size;
            end
            EM_START:
            begin
                pos_next = CFG_W'(1);
                s_next   = '0;
            end
            EM_SEG_EVAL:
            begin
                cidx_next = seg_begin[ADDR_W-1:0];
                rem_next  = len_eff;
                pos_next  = pos_reg + len_eff;
            end
            EM_BYTES:
            begin
                cidx_next = cidx_reg + ADDR_W'(1);
                rem_next  = rem_reg - CFG_W'(1);
            end
            EM_SEG_NEXT:
            begin
                if (!last_seg && slash_ok)
                begin
                    pos_next = pos_reg + CFG_W'(1);
                    s_next   = s_plus;
                end
            end
            default:
            begin
                b_next = b_reg;
            end
        endcase

        // One byte of holdback so the final byte can carry the last flag.
        if (new_vld)
        begin
            pend_vld_next  = 1'b1;
            pend_char_next = new_char;
            if (pend_vld_reg)
            begin
                out_valid_next = 1'b1;
                out_char_next  = pend_char_reg;
            end
        end
        else if (state_reg == EM_FINISH)
        begin
            pend_vld_next  = 1'b0;
            out_valid_next = 1'b1;
            out_char_next  = pend_char_reg;
            out_last_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= EM_IDLE;
            rd_vld_reg    <= 1'b0;
            pend_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            s_reg         <= '0;
            rem_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_vld_reg    <= rd_vld_next;
            pend_vld_reg  <= pend_vld_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
            s_reg         <= s_next;
            rem_reg       <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg         <= b_next;
        pos_reg       <= pos_next;
        cidx_reg      <= cidx_next;
        pend_char_reg <= pend_char_next;
        out_char_reg  <= out_char_next;
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== rtl/core/path_normalizer.sv =====
// ----------------------------------------------------------------------------
// path_normalizer
// Canonicalizes an absolute path streamed in one byte per transaction.
// ----------------------------------------------------------------------------
// Loading: one path byte per cycle; busy stays low until the zero terminator.
// The terminator raises busy; busy falls as the byte with out_last is output.
// The receiver cannot stall; out_valid marks each byte for exactly one cycle.
// Reset (rst_n, asynchronous) clears the control state and sets buffer_size to
// 64; the byte and segment memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module path_normalizer
    import pn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [CHAR_W-1:0] path_char,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_data,
    output logic              out_valid,
    output logic [CHAR_W-1:0] out_char,
    output logic              out_last
);

    // The buffer size register limits both the stored input and the output.
    len_t buffer_size_reg;
    len_t size;

    logic              accept;
    char_wr_t          char_wr;
    seg_wr_t           seg_wr;
    path_info_t        info;
    logic [SEG_AW-1:0] seg_raddr;
    logic [SEG_W-1:0]  seg_rdata;
    logic [ADDR_W-1:0] char_raddr;
    logic [CHAR_W-1:0] char_rdata;
    logic              done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_size_reg <= BUF_RESET;
        end
        else if (cfg_we)
        begin
            buffer_size_reg <= cfg_data;
        end
    end

    // Out-of-range sizes saturate to the supported range of 2 to 64 bytes.
    assign size   = eff_size(buffer_size_reg);

    // A transaction is taken whenever the emitter is idle.
    assign accept = start && !busy;

    // The parser writes each byte that fits into the store and pushes or pops the
    // segment stack when a slash or the terminator closes a component.
    pn_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .path_char (path_char),
        .size      (size),
        .done      (done),
        .char_wr   (char_wr),
        .seg_wr    (seg_wr),
        .info      (info)
    );

    pn_char_mem u_char_mem (
        .clk   (clk),
        .wr    (char_wr),
        .raddr (char_raddr),
        .rdata (char_rdata)
    );

    pn_seg_mem u_seg_mem (
        .clk   (clk),
        .wr    (seg_wr),
        .raddr (seg_raddr),
        .rdata (seg_rdata)
    );

    // The emitter replays the segment stack from the bottom, trims segments
    // that would overflow the buffer, and inserts separators between them.
    pn_emitter u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .info       (info),
        .size       (size),
        .seg_rdata  (seg_rdata),
        .char_rdata (char_rdata),
        .seg_raddr  (seg_raddr),
        .char_raddr (char_raddr),
        .busy       (busy),
        .done       (done),
        .out_valid  (out_valid),
        .out_char   (out_char),
        .out_last   (out_last)
    );

endmodule

// ===== rtl/core/pn_checker.sv =====
// ----------------------------------------------------------------------------
// pn_checker
// Port-level checks on the path normalizer's transaction ordering.
// ----------------------------------------------------------------------------
module pn_checker
    import pn_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic [CHAR_W-1:0] path_char,
    input logic              out_valid,
    input logic              out_last
);

    // The last flag only appears on a valid byte.
    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_last |-> out_valid)
        else $error("out_last without out_valid");

    // Bytes before the last one are only emitted while the block is busy.
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_last) |-> busy)
        else $error("non-final byte emitted while idle");

    // An accepted terminator starts the rebuild.
    a_term_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && path_char == CHAR_NUL) |=> busy)
        else $error("terminator did not start output");

    // Busy only rises after an accepted terminator.
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && path_char == CHAR_NUL))
        else $error("busy rose without a terminator");

    // Two paths never run together: the last byte is followed by a gap.
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_last |=> !out_valid)
        else $error("byte emitted right after the last byte");

endmodule

bind path_normalizer pn_checker u_pn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .path_char (path_char),
    .out_valid (out_valid),
    .out_last  (out_last)
);
